// ===== hw/rtl/omsd_pkg.sv =====
// Shared constants, types and state encoding for the per-leg force statistics block.
package omsd_pkg;

    localparam int LEG_COUNT  = 4;
    localparam int SLOT_COUNT = 2 * LEG_COUNT;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int LEG_W      = 2;
    localparam int CNT_W      = 32;
    localparam int SQ_W       = 48;
    localparam int DSOR_W     = 32;
    localparam int NBITS_W    = 6;
    localparam int ROOT_W     = 24;
    localparam int PROD_W     = 34;

    // Configuration register indexes
    localparam logic [1:0] CFG_STANCE_MEAN  = 2'd0;
    localparam logic [1:0] CFG_STANCE_SIGMA = 2'd1;
    localparam logic [1:0] CFG_SWING_MEAN   = 2'd2;
    localparam logic [1:0] CFG_SWING_SIGMA  = 2'd3;

    localparam logic signed [15:0] RST_STANCE_MEAN  = 16'sd6400;
    localparam logic        [15:0] RST_STANCE_SIGMA = 16'd800;
    localparam logic signed [15:0] RST_SWING_MEAN   = 16'sd0;
    localparam logic        [15:0] RST_SWING_SIGMA  = 16'd4000;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [SQ_W-1:0]  SQ_MAX  = {SQ_W{1'b1}};

    // Quotient bits for the mean step and the variance step
    localparam logic [NBITS_W-1:0] MEAN_DIV_BITS = 6'd17;
    localparam logic [NBITS_W-1:0] VAR_DIV_BITS  = 6'd48;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV_MEAN,
        ST_UPDATE,
        ST_ACCUM,
        ST_DIV_VAR,
        ST_SQRT,
        ST_OUT
    } omsd_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// ===== hw/rtl/omsd_div.sv =====
// Restoring divider, one quotient bit per cycle, 48-bit dividend by 32-bit divisor.
module omsd_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [omsd_pkg::SQ_W-1:0]     dend,    // left-aligned dividend
    input  logic [omsd_pkg::DSOR_W-1:0]   dsor,
    input  logic [omsd_pkg::NBITS_W-1:0]  nbits,
    output omsd_pkg::unit_stat_t          stat,
    output logic [omsd_pkg::SQ_W-1:0]     quot
);
    import omsd_pkg::*;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [NBITS_W-1:0]  cnt_reg, cnt_next;
    logic [DSOR_W-1:0]   rem_reg, rem_next;
    logic [SQ_W-1:0]     quo_reg, quo_next;
    logic [DSOR_W-1:0]   dsor_reg, dsor_next;
    logic [DSOR_W:0]     trial;
    logic [DSOR_W:0]     diff;
    logic                ge;

    assign trial = {rem_reg, quo_reg[SQ_W-1]};
    assign ge    = trial >= {1'b0, dsor_reg};
    assign diff  = trial - {1'b0, dsor_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsor_next = dsor_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = nbits;
            rem_next  = '0;
            quo_next  = dend;
            dsor_next = dsor;
        end else if (busy_reg) begin
            rem_next = ge ? diff[DSOR_W-1:0] : trial[DSOR_W-1:0];
            quo_next = {quo_reg[SQ_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == NBITS_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dsor_reg <= dsor_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quo_reg;

endmodule

// ===== hw/rtl/omsd_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
module omsd_sqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [omsd_pkg::SQ_W-1:0]     radicand,
    output omsd_pkg::unit_stat_t          stat,
    output logic [omsd_pkg::ROOT_W-1:0]   root
);
    import omsd_pkg::*;

    localparam int REM_W = ROOT_W + 2;
    localparam int CNT_SQ_W = $clog2(ROOT_W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_SQ_W-1:0] cnt_reg, cnt_next;
    logic [SQ_W-1:0]     val_reg, val_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [REM_W-1:0]    rem_sh;
    logic [REM_W-1:0]    trial;
    logic                ge;

    assign rem_sh = {rem_reg[REM_W-3:0], val_reg[SQ_W-1:SQ_W-2]};
    assign trial  = {root_reg, 2'b01};
    assign ge     = rem_sh >= trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_SQ_W'(ROOT_W);
            val_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            rem_next  = ge ? (rem_sh - trial) : rem_sh;
            root_next = {root_reg[ROOT_W-2:0], ge};
            val_next  = {val_reg[SQ_W-3:0], 2'b00};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_SQ_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

// ===== hw/rtl/online_mean_stddev_per_leg.sv =====
// Top level: per-leg, per-class Welford running mean and standard deviation of force.
//
// One force sample per transfer updates the slot picked by leg and class (stance or
// swing) and yields one result: new mean, sample sigma sqrt(M2/(n-1)) and count. One
// sample is in work at a time; s_tready is high only while the sequencer idles, but a
// finished result may still wait in the output register. A slot holding fewer than
// two samples reports its class's initial sigma and skips the variance divide and the
// square root. The work is done by the single restoring divider (delta/n, then
// M2/(n-1), one quotient bit per cycle) and the square root unit (one root bit per
// cycle). Units: force, mean and sigma in 1/16 N, M2 in 1/256 N^2 saturating at
// 2^48-1, count saturating at 2^32-1. Leg indexes at or beyond LEG_COUNT map to the
// last leg. No clearing pass is needed after reset.
module online_mean_stddev_per_leg (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] force_sample
    input  logic [2:0]  s_tuser,   // [0] in_stance, [2:1] leg
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [15:0] running_mean, [31:16] running_sigma,
                                   // [63:32] sample_count
    output logic [0:0]  m_tuser,   // [0] sum_saturated
    // configuration writes
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import omsd_pkg::*;

    // configuration
    logic signed [15:0] init_stance_mean_reg;
    logic        [15:0] init_stance_sigma_reg;
    logic signed [15:0] init_swing_mean_reg;
    logic        [15:0] init_swing_sigma_reg;

    // slot storage; mean and M2 are only trusted once count is nonzero
    logic        [CNT_W-1:0] count_mem [SLOT_COUNT];
    logic signed [15:0]      mean_mem  [SLOT_COUNT];
    logic        [SQ_W-1:0]  sq_mem    [SLOT_COUNT];

    omsd_state_t state_reg, state_next;

    // working registers for the sample in flight
    logic signed [15:0]       x_reg;
    logic                     st_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic [CNT_W-1:0]         n_reg;
    logic signed [15:0]       mu_reg;
    logic signed [16:0]       delta_reg;
    logic [SQ_W-1:0]          m2_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [15:0]              sigma_reg;

    // output register
    logic                     m_tvalid_reg;
    logic [15:0]              out_mean_reg;
    logic [15:0]              out_sigma_reg;
    logic [CNT_W-1:0]         out_count_reg;
    logic                     out_sat_reg;

    // arithmetic units: divider shared by both divide steps, square root
    logic                     div_start;
    logic [SQ_W-1:0]          div_dend;
    logic [DSOR_W-1:0]        div_dsor;
    logic [NBITS_W-1:0]       div_nbits;
    unit_stat_t               div_stat;
    logic [SQ_W-1:0]          div_quot;
    logic                     sqrt_start;
    unit_stat_t               sqrt_stat;
    logic [ROOT_W-1:0]        sqrt_root;

    // combinational datapath
    logic [LEG_W-1:0]         leg_sat;
    logic [SLOT_W-1:0]        in_slot;
    logic [CNT_W-1:0]         n_old;
    logic [CNT_W-1:0]         n_new;
    logic signed [15:0]       init_mean;
    logic [15:0]              init_sigma;
    logic signed [15:0]       mu_old;
    logic signed [16:0]       delta_c;
    logic [16:0]              delta_abs;
    logic signed [16:0]       mu_new;
    logic signed [16:0]       resid;
    logic signed [PROD_W-1:0] prod_c;
    logic [SQ_W:0]            m2_sum;
    logic [SQ_W-1:0]          m2_sat;
    logic                     out_load;
    logic                     few_samples;

    // slot select: leg saturates to the last leg
    assign leg_sat = (int'(s_tuser[2:1]) >= LEG_COUNT) ? LEG_W'(LEG_COUNT - 1)
                                                        : LEG_W'(s_tuser[2:1]);
    assign in_slot = {leg_sat, s_tuser[0]};

    assign init_mean  = st_reg ? init_stance_mean_reg  : init_swing_mean_reg;
    assign init_sigma = st_reg ? init_stance_sigma_reg : init_swing_sigma_reg;

    // load step: empty slot starts from the class's current initial mean
    assign n_old     = count_mem[slot_reg];
    assign n_new     = (n_old == CNT_MAX) ? CNT_MAX : n_old + 1'b1;
    assign mu_old    = (n_old == '0) ? init_mean : mean_mem[slot_reg];
    assign delta_c   = 17'(x_reg) - 17'(mu_old);
    assign delta_abs = delta_c[16] ? 17'(-delta_c) : delta_c;

    // update step: quotient is |delta|/n, truncating toward zero
    assign mu_new = delta_reg[16] ? (17'(mu_reg) - 17'(div_quot[16:0]))
                                  : (17'(mu_reg) + 17'(div_quot[16:0]));
    assign resid  = 17'(x_reg) - mu_new;
    assign prod_c = delta_reg * resid;

    // accumulate step with saturation
    assign m2_sum      = {1'b0, m2_reg} + (SQ_W+1)'(prod_reg);
    assign m2_sat      = m2_sum[SQ_W] ? SQ_MAX : m2_sum[SQ_W-1:0];
    assign few_samples = n_reg < CNT_W'(2);

    omsd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dend    (div_dend),
        .dsor    (div_dsor),
        .nbits   (div_nbits),
        .stat    (div_stat),
        .quot    (div_quot)
    );

    omsd_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (div_quot),
        .stat     (sqrt_stat),
        .root     (sqrt_root)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (s_tvalid) state_next = ST_LOAD;
            ST_LOAD:     state_next = ST_DIV_MEAN;
            ST_DIV_MEAN: if (div_stat.done) state_next = ST_UPDATE;
            ST_UPDATE:   state_next = ST_ACCUM;
            ST_ACCUM:    state_next = few_samples ? ST_OUT : ST_DIV_VAR;
            ST_DIV_VAR:  if (div_stat.done) state_next = ST_SQRT;
            ST_SQRT:     if (sqrt_stat.done) state_next = ST_OUT;
            ST_OUT:      if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready   = 1'b0;
        div_start  = 1'b0;
        div_dend   = {delta_abs, {(SQ_W-17){1'b0}}};
        div_dsor   = n_new;
        div_nbits  = MEAN_DIV_BITS;
        sqrt_start = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_LOAD: div_start = 1'b1;
            ST_ACCUM: begin
                div_start = !few_samples;
                div_dend  = m2_sat;
                div_dsor  = n_reg - 1'b1;
                div_nbits = VAR_DIV_BITS;
            end
            ST_DIV_VAR: sqrt_start = div_stat.done;
            ST_OUT:     out_load = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_stance_mean_reg  <= RST_STANCE_MEAN;
            init_stance_sigma_reg <= RST_STANCE_SIGMA;
            init_swing_mean_reg   <= RST_SWING_MEAN;
            init_swing_sigma_reg  <= RST_SWING_SIGMA;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_STANCE_MEAN:  init_stance_mean_reg  <= cfg_wdata;
                CFG_STANCE_SIGMA: init_stance_sigma_reg <= cfg_wdata;
                CFG_SWING_MEAN:   init_swing_mean_reg   <= cfg_wdata;
                CFG_SWING_SIGMA:  init_swing_sigma_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // slot counts reset to empty
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                count_mem[i] <= '0;
            end
        end else if (state_reg == ST_ACCUM) begin
            count_mem[slot_reg] <= n_reg;
        end
    end

    // slot mean and M2 write-back
    always_ff @(posedge aclk) begin
        if (state_reg == ST_ACCUM) begin
            mean_mem[slot_reg] <= mu_reg;
            sq_mem[slot_reg]   <= m2_sat;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                x_reg    <= s_tdata;
                st_reg   <= s_tuser[0];
                slot_reg <= in_slot;
            end
            ST_LOAD: begin
                n_reg     <= n_new;
                mu_reg    <= mu_old;
                delta_reg <= delta_c;
                m2_reg    <= (n_old == '0) ? '0 : sq_mem[slot_reg];
            end
            ST_UPDATE: begin
                mu_reg   <= mu_new[15:0];
                prod_reg <= PROD_W'(prod_c);
            end
            ST_ACCUM: begin
                m2_reg    <= m2_sat;
                sigma_reg <= init_sigma;
            end
            ST_SQRT: begin
                if (sqrt_stat.done) begin
                    sigma_reg <= (sqrt_root > ROOT_W'(16'hFFFF)) ? 16'hFFFF
                                                                 : sqrt_root[15:0];
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_mean_reg  <= mu_reg;
            out_sigma_reg <= sigma_reg;
            out_count_reg <= n_reg;
            out_sat_reg   <= (m2_reg == SQ_MAX);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_count_reg, out_sigma_reg, out_mean_reg};
    assign m_tuser  = out_sat_reg;

`ifndef SYNTHESIS
    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_DIV_MEAN || state_reg == ST_DIV_VAR))
        else $error("divider finished outside a divide state");

    a_sqrt_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_stat.done |-> state_reg == ST_SQRT)
        else $error("square root finished outside its state");

    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(div_stat.busy && sqrt_stat.busy))
        else $error("divider and square root busy together");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[63:32] != 32'd0)
        else $error("result with zero count");

    a_sat_needs_two: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> m_tdata[63:32] >= 32'd2)
        else $error("saturated sum with fewer than two samples");
`endif

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the per-leg Welford force statistics block.
module testbench;
    import omsd_pkg::*;

    typedef struct packed {
        logic signed [15:0] force_sample;
        logic               in_stance;
        logic [1:0]         leg;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] mean;
        logic [15:0]        sigma;
        logic [31:0]        count;
        logic               sat;
    } stat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;

    online_mean_stddev_per_leg dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic signed [15:0] cfg_mean [2];     // indexed by class: 0 swing, 1 stance
    logic [15:0]        cfg_sigma [2];
    logic [31:0]        acc_count [SLOT_COUNT];
    logic signed [15:0] acc_mean [SLOT_COUNT];
    logic [47:0]        acc_m2 [SLOT_COUNT];

    sample_t pending_samples [$];
    stat_t   expected_stats [$];
    int      mismatches = 0;
    longint  cycles = 0;
    bit      feed_done = 0;
    int      tx_gap = 0;
    int      rx_gap = 0;

    function automatic int rand_gap();
        int r;
        r = $urandom_range(99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(3);
        return $urandom_range(150, 20);
    endfunction

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Welford update of one slot; returns the result the block should emit
    function automatic stat_t welford_update(sample_t smp);
        stat_t       r;
        int          slot;
        logic [31:0] n;
        longint      x, mu, delta, resid;
        logic [63:0] prod, m2, q, rt;
        slot = int'(smp.leg) * 2 + int'(smp.in_stance);
        n = acc_count[slot];
        x = longint'(smp.force_sample);
        mu = (n == 0) ? longint'(cfg_mean[smp.in_stance]) : longint'(acc_mean[slot]);
        if (n != CNT_MAX) n++;
        delta = x - mu;
        mu = mu + delta / longint'({32'd0, n});   // truncates toward zero
        resid = x - mu;
        prod = 64'(delta * resid);
        m2 = {16'd0, acc_m2[slot]};
        if (prod > {16'd0, SQ_MAX} - m2) m2 = {16'd0, SQ_MAX};
        else m2 += prod;
        acc_count[slot] = n;
        acc_mean[slot] = 16'(mu);
        acc_m2[slot] = m2[47:0];
        if (n < 2) begin
            r.sigma = cfg_sigma[smp.in_stance];
        end else begin
            q = m2 / {32'd0, n - 32'd1};
            rt = isqrt(q);
            r.sigma = (rt > 64'hFFFF) ? 16'hFFFF : rt[15:0];
        end
        r.mean = 16'(mu);
        r.count = n;
        r.sat = (m2[47:0] == SQ_MAX);
        return r;
    endfunction

    // driver: one transfer from the pending queue, random gaps between
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_stats.push_back(welford_update(pending_samples.pop_front()));
                tx_gap = rand_gap();
            end
            if ((!s_tvalid || s_tready) ) begin
                if (tx_gap > 0 || pending_samples.size() == 0 ||
                    (s_tvalid && s_tready && pending_samples.size() == 0)) begin
                    if (tx_gap > 0) tx_gap--;
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_samples[0].force_sample;
                    s_tuser  <= {pending_samples[0].leg, pending_samples[0].in_stance};
                end
            end
        end
    end

    // monitor: compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        stat_t got, exp_s;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = '{mean: m_tdata[15:0], sigma: m_tdata[31:16],
                        count: m_tdata[63:32], sat: m_tuser[0]};
                if (expected_stats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result mean=%0d sigma=%0d count=%0d sat=%0b",
                                 got.mean, got.sigma, got.count, got.sat);
                end else begin
                    exp_s = expected_stats.pop_front();
                    if (got !== exp_s) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp mean/sigma/count/sat=",
                                      "%0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b"},
                                     exp_s.mean, exp_s.sigma, exp_s.count, exp_s.sat,
                                     got.mean, got.sigma, got.count, got.sat);
                    end
                end
            end
            if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(9) == 0) rx_gap = rand_gap();
            end
        end
    end

    // generous limit: covers the work and the worst gaps of every item
    always @(posedge aclk) begin
        if (cycles > 2_000_000) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] addr, logic [15:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (addr)
            CFG_STANCE_MEAN:  cfg_mean[1]  = value;
            CFG_STANCE_SIGMA: cfg_sigma[1] = value;
            CFG_SWING_MEAN:   cfg_mean[0]  = value;
            CFG_SWING_SIGMA:  cfg_sigma[0] = value;
            default: ;
        endcase
    endtask

    task automatic drain();
        wait (pending_samples.size() == 0 && !s_tvalid && expected_stats.size() == 0);
        repeat (120) @(posedge aclk);
    endtask

    task automatic add_sample(logic [15:0] f, logic st, logic [1:0] lg);
        pending_samples.push_back('{force_sample: f, in_stance: st, leg: lg});
    endtask

    // random sample: mostly realistic force levels per class, some extremes
    task automatic add_random(int per_leg_bias);
        logic [15:0] f;
        logic        st;
        int          r;
        st = $urandom_range(1);
        r = $urandom_range(99);
        if (r < 70) f = st ? 16'($urandom_range(7000, 5000)) : 16'($urandom_range(300));
        else if (r < 85) f = 16'($urandom);
        else if (r < 95) f = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        else f = $urandom_range(1) ? 16'h0000 : 16'hFFFF;
        add_sample(f, st, per_leg_bias >= 0 ? 2'(per_leg_bias) : 2'($urandom_range(3)));
    endtask

    initial begin
        cfg_mean[1] = RST_STANCE_MEAN;
        cfg_sigma[1] = RST_STANCE_SIGMA;
        cfg_mean[0] = RST_SWING_MEAN;
        cfg_sigma[0] = RST_SWING_SIGMA;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            acc_count[i] = 0;
            acc_m2[i] = 0;
            acc_mean[i] = (i & 1) ? RST_STANCE_MEAN : RST_SWING_MEAN;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // initial means changed before any slot is touched: empty slots follow them
        write_reg(CFG_STANCE_MEAN, 16'h7FFF);
        write_reg(CFG_SWING_MEAN, 16'h8000);
        write_reg(CFG_STANCE_SIGMA, 16'hFFFF);
        write_reg(CFG_SWING_SIGMA, 16'h0000);

        // directed: extremes, both classes, every leg, big swings to pump M2
        add_sample(16'h8000, 1'b1, 2'd0);
        add_sample(16'h7FFF, 1'b0, 2'd0);
        add_sample(16'h7FFF, 1'b1, 2'd0);
        add_sample(16'h8000, 1'b0, 2'd0);
        add_sample(16'h0000, 1'b1, 2'd1);
        add_sample(16'hFFFF, 1'b0, 2'd1);
        add_sample(16'h0001, 1'b1, 2'd1);
        add_sample(16'h1234, 1'b0, 2'd2);
        add_sample(16'h1234, 1'b0, 2'd2);
        add_sample(16'h1234, 1'b0, 2'd2);
        for (int i = 0; i < 12; i++)
            add_sample(i[0] ? 16'h7FFF : 16'h8000, 1'b1, 2'd3);
        drain();

        // initial values flipped to extremes of opposite sign, then the two still untouched slots
        write_reg(CFG_STANCE_MEAN, 16'h8000);
        write_reg(CFG_SWING_MEAN, 16'h7FFF);
        write_reg(CFG_STANCE_SIGMA, 16'd0);
        write_reg(CFG_SWING_SIGMA, 16'hFFFF);
        add_sample(16'h0100, 1'b1, 2'd2);
        add_sample(16'h0100, 1'b0, 2'd3);
        for (int i = 0; i < 500; i++) add_random(-1);
        drain();

        write_reg(CFG_STANCE_MEAN, RST_STANCE_MEAN);
        write_reg(CFG_STANCE_SIGMA, RST_STANCE_SIGMA);
        write_reg(CFG_SWING_MEAN, RST_SWING_MEAN);
        write_reg(CFG_SWING_SIGMA, RST_SWING_SIGMA);
        for (int i = 0; i < 500; i++) add_random(-1);
        drain();

        write_reg(CFG_STANCE_MEAN, 16'd100);
        write_reg(CFG_SWING_SIGMA, 16'd1);
        for (int i = 0; i < 530; i++) add_random(i < 200 ? 0 : -1);
        drain();

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
